@@ sv/plm_pkg.sv @@
`default_nettype none
package plm_pkg;

  localparam int MAX_RULES_DEF      = 16;
  localparam int MAX_PREFIX_LEN_DEF = 64;

  localparam int TYPE_W = 2;
  localparam int SLOT_W = 4;
  localparam int CPOS_W = 6;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int CNT_W  = 5;
  // slot number carried along the chain, wide enough for 256 rules
  localparam int IDX_W  = 8;

  localparam logic [BYTE_W-1:0] SLASH   = 8'h2F;
  localparam logic [LEN_W-1:0]  POS_MAX = 7'd127;

  typedef enum logic [TYPE_W-1:0] {
    REQ_WR_BYTE   = 2'd0,
    REQ_SET_LEN   = 2'd1,
    REQ_PATH_BYTE = 2'd2,
    REQ_END       = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_DONE
  } state_e;

  // broadcast from the controller to every rule cell
  typedef struct packed {
    logic              byte_we;
    logic              len_we;
    logic [SLOT_W-1:0] slot;
    logic [CPOS_W-1:0] char_pos;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  wr_len;
    logic              path_rd;
    logic              end_rd;
    logic [LEN_W-1:0]  pos;
    logic              cmp_v;
    logic [BYTE_W-1:0] cmp_byte;
    logic              eval;
    logic [CNT_W-1:0]  count;
  } bcast_t;

  // best match so far, passed from cell to cell
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [LEN_W-1:0] len;
  } best_t;

endpackage
`default_nettype wire

@@ sv/path_longest_prefix_match_core.sv @@
`default_nettype none
// Rule writes and path bytes: one beat per cycle, no result.
// End of path: the result is registered once the best match has walked down the chain of rule
//   cells, one cell per cycle; the input stays stalled until then, and longer while the
//   previous result waits unread.
// Reset (async, active low) clears rule_count, all rule lengths and the path state;
//   stored prefix bytes are not cleared.
module path_longest_prefix_match_core #(
  parameter int MAX_RULES      = plm_pkg::MAX_RULES_DEF,
  parameter int MAX_PREFIX_LEN = plm_pkg::MAX_PREFIX_LEN_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // config
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [plm_pkg::CNT_W-1:0]     cfg_data_i,
  // request beats
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [plm_pkg::TYPE_W-1:0]    req_type_i,
  input  wire logic [plm_pkg::SLOT_W-1:0]    rule_slot_i,
  input  wire logic [plm_pkg::CPOS_W-1:0]    char_pos_i,
  input  wire logic [plm_pkg::BYTE_W-1:0]    data_byte_i,
  input  wire logic [plm_pkg::LEN_W-1:0]     rule_length_i,
  // result beats
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               match_found_o,
  output logic      [plm_pkg::SLOT_W-1:0]    rule_index_o,
  output logic      [plm_pkg::LEN_W-1:0]     match_length_o
);
  import plm_pkg::*;

  localparam int SCW = MAX_RULES > 1 ? $clog2(MAX_RULES) : 1;

  state_e            state_q, state_d;
  logic [SCW-1:0]    scan_q, scan_d;
  logic [CNT_W-1:0]  count_q;
  logic [LEN_W-1:0]  pos_q;
  logic              cmp_v_q;
  logic [BYTE_W-1:0] cmp_byte_q;
  logic              out_valid_q;
  best_t             res_q;

  logic              in_acc;
  logic              load;
  logic              path_rd;
  logic [LEN_W-1:0]  len_sat;
  bcast_t            bc;
  best_t             chain [MAX_RULES+1];

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;

  // path bytes past the saturation point are taken but not examined
  assign path_rd = in_acc && (req_e'(req_type_i) == REQ_PATH_BYTE) && (pos_q < POS_MAX);
  assign len_sat = (int'(rule_length_i) > MAX_PREFIX_LEN) ?
                   LEN_W'(MAX_PREFIX_LEN) : rule_length_i;

  always_comb begin
    bc          = '0;
    bc.byte_we  = in_acc && (req_e'(req_type_i) == REQ_WR_BYTE) &&
                  (int'(char_pos_i) < MAX_PREFIX_LEN);
    bc.len_we   = in_acc && (req_e'(req_type_i) == REQ_SET_LEN);
    bc.slot     = rule_slot_i;
    bc.char_pos = char_pos_i;
    bc.data     = data_byte_i;
    bc.wr_len   = len_sat;
    bc.path_rd  = path_rd;
    bc.end_rd   = in_acc && (req_e'(req_type_i) == REQ_END);
    bc.pos      = pos_q;
    bc.cmp_v    = cmp_v_q;
    bc.cmp_byte = cmp_byte_q;
    bc.eval     = state_q == ST_EVAL;
    bc.count    = count_q;
  end

  // chain of rule cells; slot 0 sees an empty match
  assign chain[0] = '0;

  for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
    plm_cell #(
      .IDX            (g),
      .MAX_PREFIX_LEN (MAX_PREFIX_LEN)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .bc_i   (bc),
      .best_i (chain[g]),
      .best_o (chain[g+1])
    );
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    in_ready_o = 1'b0;
    load       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_acc && (req_e'(req_type_i) == REQ_END)) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // cells latch their candidate flag and clear the path state
        scan_d  = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        scan_d = scan_q + SCW'(1);
        if (scan_q == SCW'(MAX_RULES - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      cmp_v_q <= path_rd;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
      if (state_q == ST_EVAL) begin
        pos_q <= '0;
      end else if (path_rd) begin
        pos_q <= pos_q + LEN_W'(1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (path_rd) begin
      cmp_byte_q <= data_byte_i;
    end
    if (load) begin
      res_q <= chain[MAX_RULES];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign match_found_o  = res_q.found;
  assign rule_index_o   = SLOT_W'(res_q.idx);
  assign match_length_o = res_q.len;

  // end marker always starts an evaluation
  a_end_eval : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (req_e'(req_type_i) == REQ_END)) |=> (state_q == ST_EVAL))
    else $error("end marker did not start evaluation");

  // path state is cleared once the candidates are latched
  a_eval_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |=> ((state_q == ST_SCAN) && (pos_q == '0) && !cmp_v_q))
    else $error("path state not cleared after evaluation");

  // a miss reports zero slot and zero length
  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !match_found_o) |-> ((rule_index_o == '0) && (match_length_o == '0)))
    else $error("miss result carries nonzero fields");

  // winning length never exceeds the prefix capacity
  a_len_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(match_length_o) <= MAX_PREFIX_LEN))
    else $error("match length out of range");

  // no request is taken while a result is being worked out
  a_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) || (state_q == ST_EVAL)) |-> !in_ready_o)
    else $error("input taken during evaluation");

endmodule
`default_nettype wire

@@ sv/plm_ram.sv @@
`default_nettype none
module plm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ sv/plm_cell.sv @@
`default_nettype none
module plm_cell #(
  parameter int IDX            = 0,
  parameter int MAX_PREFIX_LEN = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire plm_pkg::bcast_t bc_i,
  input  wire plm_pkg::best_t  best_i,
  output plm_pkg::best_t       best_o
);
  import plm_pkg::*;

  localparam int AW = MAX_PREFIX_LEN > 1 ? $clog2(MAX_PREFIX_LEN) : 1;

  logic [LEN_W-1:0]  len_q;
  logic              eq_q;
  logic              sl_q;
  logic              lt_q;
  logic              at_q;
  logic              cand_q;
  best_t             best_q;

  logic              we;
  logic              re;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [BYTE_W-1:0] rdata;
  logic              ok;
  best_t             best_d;

  always_comb begin
    we    = bc_i.byte_we && (int'(bc_i.slot) == IDX);
    re    = bc_i.path_rd || bc_i.end_rd;
    waddr = AW'(bc_i.char_pos);
    // end marker reads the last prefix byte, a path byte the current one
    raddr = bc_i.end_rd ? AW'(len_q - LEN_W'(1)) : AW'(bc_i.pos);
  end

  plm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PREFIX_LEN)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (bc_i.data),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // position flags sampled with the read; the compare is done in the cycle after it
  always_ff @(posedge clk_i) begin
    if (bc_i.path_rd) begin
      lt_q <= bc_i.pos < len_q;
      at_q <= bc_i.pos == len_q;
    end
  end

  always_comb begin
    ok = (int'(bc_i.count) > IDX) && eq_q && (bc_i.pos >= len_q) &&
         (((len_q != '0) && (rdata == SLASH)) || (bc_i.pos == len_q) || sl_q);
    best_d = best_i;
    if (cand_q && (len_q >= best_i.len)) begin
      best_d.found = 1'b1;
      best_d.idx   = IDX_W'(IDX);
      best_d.len   = len_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      eq_q   <= 1'b1;
      sl_q   <= 1'b0;
      cand_q <= 1'b0;
      best_q <= '0;
    end else begin
      if (bc_i.len_we && (int'(bc_i.slot) == IDX)) begin
        len_q <= bc_i.wr_len;
      end
      if (bc_i.cmp_v) begin
        if (lt_q && (rdata != bc_i.cmp_byte)) begin
          eq_q <= 1'b0;
        end
        if (at_q) begin
          sl_q <= bc_i.cmp_byte == SLASH;
        end
      end
      if (bc_i.eval) begin
        cand_q <= ok;
        eq_q   <= 1'b1;
        sl_q   <= 1'b0;
      end
      best_q <= best_d;
    end
  end

  assign best_o = best_q;

endmodule
`default_nettype wire

@@ sim/path_longest_prefix_match_core_test.sv @@
`timescale 1ns / 1ps
module path_longest_prefix_match_core_test;
  import plm_pkg::*;

  localparam int RULES     = MAX_RULES_DEF;
  localparam int PLEN_MAX  = MAX_PREFIX_LEN_DEF;
  localparam int TAIL_CYC  = 40;    // well past the result latency
  localparam int SEG_ITEMS = 105;   // random request beats per config segment
  localparam int SEGMENTS  = 8;

  typedef logic [BYTE_W-1:0] octet_t;

  localparam octet_t CH_A = 8'h61;
  localparam octet_t CH_B = 8'h62;
  localparam octet_t CH_X = 8'h78;

  // one request beat as it goes onto the wire
  typedef struct {
    req_e              kind;
    logic [SLOT_W-1:0] slot;
    logic [CPOS_W-1:0] cpos;
    octet_t            data;
    logic [LEN_W-1:0]  rlen;
  } path_req_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
    logic [LEN_W-1:0]  len;
  } match_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CNT_W-1:0]     cfg_data = '0;
  logic                 cfg_ready;
  logic                 in_valid = 1'b0;
  logic [TYPE_W-1:0]    req_type = '0;
  logic [SLOT_W-1:0]    rule_slot = '0;
  logic [CPOS_W-1:0]    char_pos = '0;
  octet_t               data_byte = '0;
  logic [LEN_W-1:0]     rule_length = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 match_found;
  logic [SLOT_W-1:0]    rule_index;
  logic [LEN_W-1:0]     match_length;

  path_longest_prefix_match_core DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .req_type_i    (req_type),
    .rule_slot_i   (rule_slot),
    .char_pos_i    (char_pos),
    .data_byte_i   (data_byte),
    .rule_length_i (rule_length),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .match_found_o (match_found),
    .rule_index_o  (rule_index),
    .match_length_o(match_length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Matcher model: rule table, per-rule path compare state, rule_count.
  // Updated in beat order at the edge where each request beat is taken.
  // ---------------------------------------------------------------------------
  octet_t           rule_bytes [RULES][PLEN_MAX];  // unwritten entries stay X, never read
  bit [LEN_W-1:0]   pfx_len    [RULES];
  bit               cell_equal [RULES];             // path still equal to the prefix so far
  bit               cell_slash [RULES];             // path byte right after the prefix is '/'
  bit [LEN_W-1:0]   path_pos;
  bit [CNT_W-1:0]   rules_used;
  match_t           match_q [$];                    // results owed by the block, oldest first

  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               errors = 0;

  function automatic void clear_path_state();
    foreach (cell_equal[i]) begin
      cell_equal[i] = 1'b1;
      cell_slash[i] = 1'b0;
    end
    path_pos = '0;
  endfunction

  function automatic void take_request(path_req_t r);
    int     limit;
    bit     hit;
    match_t best;
    case (r.kind)
      REQ_WR_BYTE: rule_bytes[r.slot][r.cpos] = r.data;
      REQ_SET_LEN: pfx_len[r.slot] = (r.rlen > PLEN_MAX) ? LEN_W'(PLEN_MAX) : r.rlen;
      REQ_PATH_BYTE: begin
        // position saturates; bytes from there on are not compared
        if (path_pos < POS_MAX) begin
          for (int i = 0; i < RULES; i++) begin
            if (path_pos < pfx_len[i]) begin
              if (rule_bytes[i][path_pos] != r.data) cell_equal[i] = 1'b0;
            end else if (path_pos == pfx_len[i]) begin
              cell_slash[i] = (r.data == SLASH);
            end
          end
          path_pos = path_pos + 1'b1;
        end
      end
      REQ_END: begin
        limit = (rules_used > RULES) ? RULES : int'(rules_used);
        best = '0;
        for (int i = 0; i < limit; i++) begin
          if (cell_equal[i] && path_pos >= pfx_len[i]) begin
            // a rule ending in '/' needs nothing more; otherwise the path must
            // end here or carry '/' right after the rule
            if (pfx_len[i] != 0 && rule_bytes[i][pfx_len[i] - 1'b1] == SLASH) hit = 1'b1;
            else hit = (path_pos == pfx_len[i]) || cell_slash[i];
            // >= so that the higher slot takes a tie
            if (hit && pfx_len[i] >= best.len) begin
              best.found = 1'b1;
              best.idx   = SLOT_W'(i);
              best.len   = pfx_len[i];
            end
          end
        end
        match_q.push_back(best);
        clear_path_state();
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus side. gen_* mirrors what has been queued so far, so paths can be
  // built from current rule text and no length ever covers an unwritten byte.
  // ---------------------------------------------------------------------------
  octet_t    gen_bytes   [RULES][PLEN_MAX];
  bit        gen_written [RULES][PLEN_MAX];
  int        gen_len     [RULES];
  path_req_t pending_q [$];
  path_req_t in_flight;
  octet_t    text_buf [$];   // scratch: rule text or path under construction
  int        issued = 0;

  function automatic void push_req(req_e kind, int unsigned slot, int unsigned cpos,
                                   int unsigned data, int unsigned rlen);
    path_req_t r;
    r.kind = kind;
    r.slot = slot[SLOT_W-1:0];
    r.cpos = cpos[CPOS_W-1:0];
    r.data = data[BYTE_W-1:0];
    r.rlen = rlen[LEN_W-1:0];
    if (kind == REQ_WR_BYTE) begin
      gen_bytes[r.slot][r.cpos]   = r.data;
      gen_written[r.slot][r.cpos] = 1'b1;
    end else if (kind == REQ_SET_LEN) begin
      gen_len[r.slot] = (r.rlen > PLEN_MAX) ? PLEN_MAX : int'(r.rlen);
    end
    pending_q.push_back(r);
    issued++;
  endfunction

  // longest run of written bytes from position zero
  function automatic int written_run(int s);
    int n;
    n = 0;
    while (n < PLEN_MAX && gen_written[s][n]) n++;
    return n;
  endfunction

  // mostly a small alphabet so rules and paths collide; sometimes any byte
  function automatic octet_t pick_char();
    if ($urandom_range(0, 9) == 0) return octet_t'($urandom_range(0, 255));
    return octet_t'(CH_A + $urandom_range(0, 2));
  endfunction

  // rule text: zero to three "/seg" pieces, sometimes a trailing '/'
  function automatic void make_text();
    text_buf.delete();
    repeat ($urandom_range(0, 3)) begin
      text_buf.push_back(SLASH);
      repeat ($urandom_range(1, 2)) text_buf.push_back(pick_char());
    end
    if ($urandom_range(0, 2) == 0) text_buf.push_back(SLASH);
  endfunction

  function automatic void fill_text(int n);
    while (text_buf.size() < n)
      text_buf.push_back(($urandom_range(0, 3) == 0) ? SLASH : pick_char());
  endfunction

  function automatic void load_rule(int s, int unsigned rlen);
    foreach (text_buf[k]) push_req(REQ_WR_BYTE, s, k, text_buf[k], $urandom);
    push_req(REQ_SET_LEN, s, $urandom, $urandom, rlen);
  endfunction

  // full-width rule; length field 64..127 so the clamp is exercised
  function automatic void load_full_rule(int s);
    text_buf.delete();
    fill_text(PLEN_MAX);
    load_rule(s, $urandom_range(PLEN_MAX, 127));
  endfunction

  // stray rule write; lengths never reach past the written bytes
  function automatic void rule_noise();
    int s;
    int run;
    s = $urandom_range(0, RULES - 1);
    if ($urandom_range(0, 1) == 1) begin
      push_req(REQ_WR_BYTE, s, $urandom_range(0, PLEN_MAX - 1), $urandom_range(0, 255),
               $urandom);
    end else begin
      run = written_run(s);
      push_req(REQ_SET_LEN, s, $urandom, $urandom,
               (run == PLEN_MAX && $urandom_range(0, 1) == 1) ?
               $urandom_range(PLEN_MAX, 127) : $urandom_range(0, run));
    end
  endfunction

  // path beats plus end marker; mixed lets rule writes land inside the path
  function automatic void send_path(bit mixed);
    foreach (text_buf[k]) begin
      push_req(REQ_PATH_BYTE, $urandom, $urandom, text_buf[k], $urandom);
      if (mixed && $urandom_range(0, 19) == 0) rule_noise();
    end
    push_req(REQ_END, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // path seeded from a live rule: exact, corrupted or cut short, then maybe a tail
  function automatic void path_from_rule();
    int s;
    int v;
    s = $urandom_range(0, RULES - 1);
    v = $urandom_range(0, 9);
    text_buf.delete();
    for (int k = 0; k < gen_len[s]; k++) text_buf.push_back(gen_bytes[s][k]);
    if (v < 2 && text_buf.size() > 0) begin
      text_buf[$urandom_range(0, text_buf.size() - 1)] = pick_char();
    end else if (v < 3 && text_buf.size() > 0) begin
      repeat ($urandom_range(1, text_buf.size())) void'(text_buf.pop_back());
    end
    v = $urandom_range(0, 2);
    if (v == 1) begin
      text_buf.push_back(SLASH);
      repeat ($urandom_range(0, 3)) text_buf.push_back(pick_char());
    end else if (v == 2) begin
      repeat ($urandom_range(1, 3)) text_buf.push_back(pick_char());
    end
  endfunction

  // runs past the position counter's saturation point
  function automatic void long_path();
    path_from_rule();
    fill_text($urandom_range(128, 140));
    send_path(1'b1);
  endfunction

  function automatic void load_table();
    for (int s = 0; s < RULES; s++) begin
      if (s == RULES - 1) begin
        load_full_rule(s);
      end else begin
        make_text();
        load_rule(s, text_buf.size());
      end
    end
  endfunction

  function automatic void directed_cases();
    // empty path: every empty rule matches, top slot wins the tie
    push_req(REQ_END, 0, 0, 0, 0);
    // no leading '/': empty rules miss
    text_buf = '{CH_X};
    send_path(1'b0);
    // bare '/': empty rules match
    text_buf = '{SLASH};
    send_path(1'b0);
    // slot 1 "/a", slot 0 "/a/"
    text_buf = '{SLASH, CH_A};
    load_rule(1, 2);
    text_buf = '{SLASH, CH_A, SLASH};
    load_rule(0, 3);
    // longer rule ending in '/' wins over "/a" with '/' after it
    text_buf = '{SLASH, CH_A, SLASH, CH_B};
    send_path(1'b0);
    // byte after "/a" is not '/': only empty rules left
    text_buf = '{SLASH, CH_A, CH_B};
    send_path(1'b0);
    // path ends right after "/a"
    text_buf = '{SLASH, CH_A};
    send_path(1'b0);
    // top prefix position and byte value, then a zero path byte
    push_req(REQ_WR_BYTE, RULES - 1, PLEN_MAX - 1, 8'hFF, 0);
    text_buf = '{8'h00};
    send_path(1'b0);
  endfunction

  function automatic void random_traffic(int budget);
    int stop;
    int pick;
    stop = issued + budget;
    while (issued < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        if ($urandom_range(0, 9) == 0) begin
          load_full_rule($urandom_range(0, RULES - 1));
        end else begin
          make_text();
          load_rule($urandom_range(0, RULES - 1), text_buf.size());
        end
      end else if (pick < 82) begin
        path_from_rule();
        send_path(1'b1);
      end else if (pick < 84) begin
        long_path();
      end else if (pick < 88) begin
        // raw bytes, zero included
        text_buf.delete();
        repeat ($urandom_range(0, 6)) text_buf.push_back(octet_t'($urandom_range(0, 255)));
        send_path(1'b1);
      end else begin
        pick = $urandom_range(0, 2);
        if (pick == 0) rule_noise();
        else if (pick == 1) push_req(REQ_PATH_BYTE, $urandom, $urandom, $urandom, $urandom);
        else push_req(REQ_END, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: one beat held until taken, random sender gaps.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bit take;
    if (in_valid && in_ready) take_request(in_flight);
    if (!in_valid || in_ready) begin
      take = pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
      if (take) begin
        in_flight = pending_q.pop_front();
        in_valid    <= 1'b1;
        req_type    <= in_flight.kind;
        rule_slot   <= in_flight.slot;
        char_pos    <= in_flight.cpos;
        data_byte   <= in_flight.data;
        rule_length <= in_flight.rlen;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each taken beat with the oldest owed result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    match_t want;
    if (rst_n && out_valid && out_ready) begin
      if (match_q.size() == 0) begin
        $display("%0t: result beat with none owed: expected none, %s %0d %0d %0d",
                 $time, "got found/index/length", match_found, rule_index, match_length);
        errors++;
      end else begin
        want = match_q.pop_front();
        if (match_found !== want.found) begin
          $display("%0t: match_found expected %0d, got %0d", $time, want.found, match_found);
          errors++;
        end
        if (rule_index !== want.idx) begin
          $display("%0t: rule_index expected %0d, got %0d", $time, want.idx, rule_index);
          errors++;
        end
        if (match_length !== want.len) begin
          $display("%0t: match_length expected %0d, got %0d", $time, want.len, match_length);
          errors++;
        end
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // rule_count goes in only while the block is idle
  task automatic write_rule_count(logic [CNT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    rules_used = value;
  endtask

  // all beats taken and all results back, then let the chain settle
  task automatic drain();
    do @(posedge clk); while (pending_q.size() != 0 || in_valid || match_q.size() != 0);
    repeat (TAIL_CYC) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, then segments pairing an idle mode with a rule_count.
  // Modes in pairs: none, sender gaps, receiver stalls, both.
  // ---------------------------------------------------------------------------
  initial begin
    logic [CNT_W-1:0] count_plan [SEGMENTS];
    count_plan = '{5'd16, 5'd31, 5'd0, 5'd0, 5'd17, 5'd0, 5'd8, 5'd16};
    count_plan[3] = CNT_W'($urandom_range(1, 15));
    count_plan[5] = CNT_W'($urandom_range(0, 31));
    clear_path_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      write_rule_count(count_plan[seg]);
      if (seg == 0) begin
        directed_cases();
        load_table();
        long_path();
      end
      random_traffic(SEG_ITEMS);
      drain();
    end
    if (errors == 0 && match_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/plm_pkg.sv
sv/plm_ram.sv
sv/plm_cell.sv
sv/path_longest_prefix_match_core.sv
sim/path_longest_prefix_match_core_test.sv
